// ===== rtl/core/gld_pkg.sv =====
package gld_pkg;

    localparam int CODE_W = 12;
    localparam int CHAR_W = 8;
    localparam int BUF_W  = 24;
    localparam int HELD_W = 5;
    localparam int CW_W   = 4;
    localparam int NFC_W  = 13;
    localparam int XY_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BITS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CODE_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLACED    = 3'd4;

    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    typedef enum logic [2:0] {
        ST_PIXEL   = 3'd0,
        ST_TAKEN   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NEED    = 3'd3,
        ST_END     = 3'd4,
        ST_CORRUPT = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MODE_AFTER_CLEAR = 2'd0,
        MODE_NORMAL      = 2'd1,
        MODE_ENDED       = 2'd2,
        MODE_CORRUPT     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_WALK_DATA,
        S_POP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic [XY_W-1:0] width;
        logic [XY_W-1:0] height;
        logic            interlaced;
    } pos_cfg_t;

    function automatic logic [3:0] eff_min(input logic [3:0] m);
        if (m < 4'd2) begin
            return 4'd2;
        end else if (m > 4'd8) begin
            return 4'd8;
        end
        return m;
    endfunction

    function automatic logic [CHAR_W-1:0] root_mask(input logic [3:0] b);
        logic [3:0] e;
        e = b;
        if (b < 4'd1) begin
            e = 4'd1;
        end else if (b > 4'd8) begin
            e = 4'd8;
        end
        return CHAR_W'((9'd1 << e) - 9'd1);
    endfunction

    function automatic logic [3:0] lace_step(input logic [1:0] p);
        case (p)
            2'd0: return 4'd8;
            2'd1: return 4'd8;
            2'd2: return 4'd4;
            default: return 4'd2;
        endcase
    endfunction

    function automatic logic [2:0] lace_start(input logic [1:0] p);
        case (p)
            2'd0: return 3'd4;
            2'd1: return 3'd2;
            2'd2: return 3'd1;
            default: return 3'd0;
        endcase
    endfunction

endpackage

// ===== rtl/core/gld_ram.sv =====
module gld_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [DATA_W-1:0]          rdata
);
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ===== rtl/core/gld_pos.sv =====
module gld_pos (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  gld_pkg::pos_cfg_t       cfg,
    output logic [15:0]             col,
    output logic [15:0]             row,
    output logic                    in_image
);
    import gld_pkg::*;

    logic [XY_W-1:0] col_reg, col_next, row_reg, row_next, col_inc;
    logic [1:0]      pass_reg, pass_next;
    logic [XY_W:0]   nr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pass_reg <= '0;
        end else begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pass_reg <= pass_next;
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        pass_next = pass_reg;
        col_inc   = col_reg + 16'd1;
        nr        = '0;
        if (advance) begin
            if (col_inc != cfg.width) begin
                col_next = col_inc;
            end else begin
                col_next = '0;
                if (!cfg.interlaced) begin
                    nr = {1'b0, row_reg} + 17'd1;
                end else begin
                    nr = {1'b0, row_reg} + 17'(lace_step(pass_reg));
                    if (pass_reg < 2'd3 && nr >= {1'b0, cfg.height}) begin
                        nr        = 17'(lace_start(pass_reg));
                        pass_next = pass_reg + 2'd1;
                    end
                end
                // The row saturates so that it never wraps back into the image.
                row_next = nr[XY_W] ? '1 : nr[XY_W-1:0];
            end
        end
    end

    assign col      = col_reg;
    assign row      = row_reg;
    assign in_image = row_reg < cfg.height;
endmodule

// ===== rtl/core/gif_lzw_pixel_decoder.sv =====
// Channel  | Handshake          | Payload
// s_       | s_valid / s_ready  | s_req_type, s_data_byte
// m_       | m_valid / m_ready  | m_status, m_pixel_index, m_pixel_x, m_pixel_y, m_pixel_in_image
// cfg_     | cfg_wr_en          | cfg_addr, cfg_wdata
//
// A push, or a fetch answered from the mode alone, is answered from the idle state; a pixel
// already on the stack goes through a stack read, then output. A fetch that decodes reads
// each code in the decode state; a root code then goes through pop and emit, while a table
// code first walks the string, one registered table read per dictionary entry, then pops.
// A short-data, end or corrupt answer is registered by the state that finds it. One item is
// in flight at a time. Reset is synchronous, active low, and needs no clearing pass. A
// stalled output holds the next item off.
module gif_lzw_pixel_decoder #(
    parameter int TABLE_DEPTH   = 4096,
    parameter int STACK_DEPTH   = 1024,
    parameter int MAX_CODE_BITS = 12
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [7:0]  m_pixel_index,
    output logic [15:0] m_pixel_x,
    output logic [15:0] m_pixel_y,
    output logic        m_pixel_in_image,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import gld_pkg::*;

    localparam int TAW = $clog2(TABLE_DEPTH);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SCW = $clog2(STACK_DEPTH + 1);
    localparam int TDW = CODE_W + CHAR_W;

    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [BUF_W-1:0]    buf_reg, buf_next;
    logic [HELD_W-1:0]   held_reg, held_next;
    logic [CW_W-1:0]     cw_reg, cw_next;
    logic [NFC_W-1:0]    nfc_reg, nfc_next;
    logic [CODE_W-1:0]   prev_reg, prev_next, cur_reg, cur_next, code_reg, code_next;
    logic [CHAR_W-1:0]   lfc_reg, lfc_next;
    logic [SCW-1:0]      cnt_reg, cnt_next, cnt_dec;
    logic [3:0]          cbits_reg, cbits_next, minsz_reg, minsz_next;
    logic [XY_W-1:0]     width_reg, width_next, height_reg, height_next;
    logic                lace_reg, lace_next;

    logic                ovalid_reg, ovalid_next, oin_reg, oin_next;
    status_t             ostat_reg, ostat_next;
    logic [CHAR_W-1:0]   oidx_reg, oidx_next;
    logic [XY_W-1:0]     ox_reg, ox_next, oy_reg, oy_next;

    logic                tbl_we, stk_we, pos_adv, pos_in;
    logic [TAW-1:0]      tbl_waddr, tbl_raddr;
    logic [TDW-1:0]      tbl_wdata, tbl_rdata;
    logic [SAW-1:0]      stk_waddr, stk_raddr;
    logic [CHAR_W-1:0]   stk_wdata, stk_rdata, rmask, fin;
    logic [XY_W-1:0]     pos_col, pos_row;
    pos_cfg_t            pos_cfg;
    logic [NFC_W-1:0]    clr_code, nfc_inc;
    logic [CODE_W-1:0]   code;
    logic [CW_W-1:0]     restart_cw;
    logic [NFC_W-1:0]    restart_nfc;
    logic [3:0]          wr_min;
    logic                accept;

    gld_ram #(.DATA_W(TDW), .DEPTH(TABLE_DEPTH)) u_table (
        .aclk(aclk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr(tbl_raddr), .rdata(tbl_rdata)
    );

    gld_ram #(.DATA_W(CHAR_W), .DEPTH(STACK_DEPTH)) u_stack (
        .aclk(aclk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    assign pos_cfg = '{width: width_reg, height: height_reg, interlaced: lace_reg};

    gld_pos u_pos (
        .aclk(aclk), .aresetn(aresetn), .advance(pos_adv), .cfg(pos_cfg),
        .col(pos_col), .row(pos_row), .in_image(pos_in)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mode_reg   <= MODE_AFTER_CLEAR;
            buf_reg    <= '0;
            held_reg   <= '0;
            cw_reg     <= 4'd9;
            nfc_reg    <= 13'd258;
            prev_reg   <= '0;
            lfc_reg    <= '0;
            cnt_reg    <= '0;
            cbits_reg  <= 4'd8;
            minsz_reg  <= 4'd8;
            width_reg  <= 16'd1;
            height_reg <= 16'd1;
            lace_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            buf_reg    <= buf_next;
            held_reg   <= held_next;
            cw_reg     <= cw_next;
            nfc_reg    <= nfc_next;
            prev_reg   <= prev_next;
            lfc_reg    <= lfc_next;
            cnt_reg    <= cnt_next;
            cbits_reg  <= cbits_next;
            minsz_reg  <= minsz_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            lace_reg   <= lace_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        code_reg  <= code_next;
        ostat_reg <= ostat_next;
        oidx_reg  <= oidx_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oin_reg   <= oin_next;
    end

    assign s_ready     = (state_reg == S_IDLE) && (!ovalid_reg || m_ready);
    assign accept      = s_valid && s_ready;
    assign rmask       = root_mask(cbits_reg);
    assign clr_code    = NFC_W'(1) << eff_min(minsz_reg);
    assign code        = CODE_W'(buf_reg & ((BUF_W'(1) << cw_reg) - BUF_W'(1)));
    assign restart_cw  = eff_min(minsz_reg) + 4'd1;
    assign restart_nfc = clr_code + 13'd2;
    assign cnt_dec     = cnt_reg - SCW'(1);
    assign nfc_inc     = nfc_reg + 13'd1;
    assign wr_min      = eff_min(cfg_wdata[3:0]);

    always_comb begin
        fin         = cur_reg[CHAR_W-1:0] & rmask;
        state_next  = state_reg;
        mode_next   = mode_reg;
        buf_next    = buf_reg;
        held_next   = held_reg;
        cw_next     = cw_reg;
        nfc_next    = nfc_reg;
        prev_next   = prev_reg;
        lfc_next    = lfc_reg;
        cnt_next    = cnt_reg;
        cur_next    = cur_reg;
        code_next   = code_reg;
        cbits_next  = cbits_reg;
        minsz_next  = minsz_reg;
        width_next  = width_reg;
        height_next = height_reg;
        lace_next   = lace_reg;
        ovalid_next = ovalid_reg && !m_ready;
        ostat_next  = ostat_reg;
        oidx_next   = oidx_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oin_next    = oin_reg;
        tbl_we      = 1'b0;
        tbl_waddr   = nfc_reg[TAW-1:0];
        tbl_wdata   = {prev_reg, fin};
        tbl_raddr   = cur_reg[TAW-1:0];
        stk_we      = 1'b0;
        stk_waddr   = cnt_reg[SAW-1:0];
        stk_wdata   = fin;
        stk_raddr   = cnt_dec[SAW-1:0];
        pos_adv     = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Non-pixel results carry zero pixel fields.
                    oidx_next = '0;
                    ox_next   = '0;
                    oy_next   = '0;
                    oin_next  = 1'b0;
                    if (s_req_type == REQ_PUSH) begin
                        ovalid_next = 1'b1;
                        if (held_reg > 5'd16) begin
                            ostat_next = ST_FULL;
                        end else begin
                            buf_next   = buf_reg | (BUF_W'(s_data_byte) << held_reg);
                            held_next  = held_reg + 5'd8;
                            ostat_next = ST_TAKEN;
                        end
                    end else if (cnt_reg != '0) begin
                        cnt_next   = cnt_dec;
                        state_next = S_EMIT;
                    end else if (mode_reg == MODE_ENDED) begin
                        ovalid_next = 1'b1;
                        ostat_next  = ST_END;
                    end else if (mode_reg == MODE_CORRUPT) begin
                        ovalid_next = 1'b1;
                        ostat_next  = ST_CORRUPT;
                    end else begin
                        state_next = S_DECODE;
                    end
                end
            end
            S_DECODE: begin
                if ({1'b0, held_reg} < {2'b0, cw_reg}) begin
                    ovalid_next = 1'b1;
                    ostat_next  = ST_NEED;
                    state_next  = S_IDLE;
                end else begin
                    buf_next  = buf_reg >> cw_reg;
                    held_next = held_reg - HELD_W'(cw_reg);
                    code_next = code;
                    if ({1'b0, code} == clr_code) begin
                        cw_next   = restart_cw;
                        nfc_next  = restart_nfc;
                        mode_next = MODE_AFTER_CLEAR;
                    end else if ({1'b0, code} == clr_code + 13'd1) begin
                        mode_next   = MODE_ENDED;
                        ovalid_next = 1'b1;
                        ostat_next  = ST_END;
                        state_next  = S_IDLE;
                    end else if (mode_reg == MODE_AFTER_CLEAR) begin
                        if ({1'b0, code} > clr_code) begin
                            mode_next   = MODE_CORRUPT;
                            cnt_next    = '0;
                            ovalid_next = 1'b1;
                            ostat_next  = ST_CORRUPT;
                            state_next  = S_IDLE;
                        end else begin
                            stk_we     = 1'b1;
                            stk_wdata  = code[CHAR_W-1:0] & rmask;
                            cnt_next   = SCW'(1);
                            prev_next  = code;
                            lfc_next   = code[CHAR_W-1:0] & rmask;
                            mode_next  = MODE_NORMAL;
                            state_next = S_POP;
                        end
                    end else if ({1'b0, code} > nfc_reg ||
                                 ({1'b0, code} == nfc_reg &&
                                  nfc_reg >= NFC_W'(TABLE_DEPTH))) begin
                        mode_next   = MODE_CORRUPT;
                        cnt_next    = '0;
                        ovalid_next = 1'b1;
                        ostat_next  = ST_CORRUPT;
                        state_next  = S_IDLE;
                    end else if ({1'b0, code} == nfc_reg) begin
                        // Code not yet in the table: previous string plus its first char.
                        stk_we     = 1'b1;
                        stk_wdata  = lfc_reg;
                        cnt_next   = SCW'(1);
                        cur_next   = prev_reg;
                        state_next = S_WALK;
                    end else begin
                        cur_next   = code;
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if ({1'b0, cur_reg} >= clr_code) begin
                    if ({1'b0, cur_reg} >= NFC_W'(TABLE_DEPTH)) begin
                        mode_next   = MODE_CORRUPT;
                        cnt_next    = '0;
                        ovalid_next = 1'b1;
                        ostat_next  = ST_CORRUPT;
                        state_next  = S_IDLE;
                    end else begin
                        state_next = S_WALK_DATA;
                    end
                end else if (cnt_reg >= SCW'(STACK_DEPTH)) begin
                    mode_next   = MODE_CORRUPT;
                    cnt_next    = '0;
                    ovalid_next = 1'b1;
                    ostat_next  = ST_CORRUPT;
                    state_next  = S_IDLE;
                end else begin
                    stk_we   = 1'b1;
                    cnt_next = cnt_reg + SCW'(1);
                    if (nfc_reg < NFC_W'(TABLE_DEPTH)) begin
                        tbl_we   = 1'b1;
                        nfc_next = nfc_inc;
                        if (nfc_inc >= (NFC_W'(1) << cw_reg) &&
                            cw_reg < CW_W'(MAX_CODE_BITS)) begin
                            cw_next = cw_reg + 4'd1;
                        end
                    end
                    prev_next  = code_reg;
                    lfc_next   = fin;
                    state_next = S_POP;
                end
            end
            S_WALK_DATA: begin
                if (cnt_reg >= SCW'(STACK_DEPTH)) begin
                    mode_next   = MODE_CORRUPT;
                    cnt_next    = '0;
                    ovalid_next = 1'b1;
                    ostat_next  = ST_CORRUPT;
                    state_next  = S_IDLE;
                end else begin
                    stk_we     = 1'b1;
                    stk_wdata  = tbl_rdata[CHAR_W-1:0];
                    cnt_next   = cnt_reg + SCW'(1);
                    cur_next   = tbl_rdata[TDW-1:CHAR_W];
                    state_next = S_WALK;
                end
            end
            S_POP: begin
                cnt_next   = cnt_dec;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                ovalid_next = 1'b1;
                ostat_next  = ST_PIXEL;
                oidx_next   = stk_rdata;
                ox_next     = pos_col;
                oy_next     = pos_row;
                oin_next    = pos_in;
                pos_adv     = 1'b1;
                state_next  = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_COLOR_BITS: cbits_next = cfg_wdata[3:0];
                REG_MIN_CODE_SIZE: begin
                    minsz_next = cfg_wdata[3:0];
                    cw_next    = wr_min + 4'd1;
                    nfc_next   = (NFC_W'(1) << wr_min) + 13'd2;
                    mode_next  = MODE_AFTER_CLEAR;
                    cnt_next   = '0;
                end
                REG_IMAGE_WIDTH:  width_next  = cfg_wdata;
                REG_IMAGE_HEIGHT: height_next = cfg_wdata;
                REG_INTERLACED:   lace_next   = cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid          = ovalid_reg;
    assign m_status         = ostat_reg;
    assign m_pixel_index    = oidx_reg;
    assign m_pixel_x        = ox_reg;
    assign m_pixel_y        = oy_reg;
    assign m_pixel_in_image = oin_reg;

`ifndef SYNTHESIS
    a_stack_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= SCW'(STACK_DEPTH))
        else $error("string stack count beyond its depth");

    a_width_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cw_reg <= CW_W'(MAX_CODE_BITS) || cw_reg == 4'd9)
        else $error("code width beyond its limit");

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> state_reg == S_IDLE)
        else $error("input taken while decoding");

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EMIT |-> !ovalid_reg)
        else $error("pixel result would overwrite a pending item");
`endif
endmodule

// ===== dv/tb_gif_lzw_pixel_decoder.sv =====
module tb_gif_lzw_pixel_decoder;
    import gld_pkg::*;

    localparam int LIMIT = 600000;
    localparam int TBL = 4096;
    localparam int STK = 1024;

    typedef struct {
        status_t     st;
        logic [7:0]  idx;
        logic [15:0] x;
        logic [15:0] y;
        logic        inimg;
    } pixel_t;

    class pixel_scoreboard;
        bit [11:0] prefix [TBL];
        bit [7:0]  suffix [TBL];
        bit [7:0]  stk [STK];
        int        sc, held, cw, nfc, prev, lfc, pass, col, row;
        bit [23:0] bbuf;
        mode_t     mode;
        bit [3:0]  cbits, mcs;
        int        iw, ih;
        bit        il;
        pixel_t    exp_q[$];
        int        errors;

        function new();
            cbits = 8; mcs = 8; iw = 1; ih = 1; il = 0;
            sc = 0; bbuf = 0; held = 0; prev = 0; lfc = 0;
            col = 0; row = 0; pass = 0; errors = 0;
            restart();
        endfunction

        function int eff_m();
            if (mcs < 2) return 2;
            if (mcs > 8) return 8;
            return mcs;
        endfunction

        function void restart();
            cw = eff_m() + 1;
            nfc = (1 << eff_m()) + 2;
            mode = MODE_AFTER_CLEAR;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] v);
            case (idx)
                REG_COLOR_BITS: cbits = v[3:0];
                REG_MIN_CODE_SIZE: begin
                    mcs = v[3:0];
                    restart();
                    sc = 0;
                end
                REG_IMAGE_WIDTH: iw = v;
                REG_IMAGE_HEIGHT: ih = v;
                REG_INTERLACED: il = v[0];
                default: ;
            endcase
        endfunction

        function bit stack_push(int c);
            if (sc >= STK) return 0;
            stk[sc] = c[7:0];
            sc++;
            return 1;
        endfunction

        function void step_pos();
            int nr;
            int st_row;
            col = (col + 1) & 'hffff;
            if (col != iw) return;
            col = 0;
            if (!il) begin
                nr = row + 1;
            end else begin
                nr = row + ((pass < 2) ? 8 : (pass == 2) ? 4 : 2);
                if (pass < 3 && nr >= ih) begin
                    st_row = (pass == 0) ? 4 : (pass == 1) ? 2 : 1;
                    nr = st_row;
                    pass++;
                end
            end
            row = (nr > 'hffff) ? 'hffff : nr;
        endfunction

        function void go_corrupt();
            mode = MODE_CORRUPT;
            sc = 0;
        endfunction

        // Decodes codes until the string stack holds a string, data runs short, or an end or corrupt code is met.
        function status_t decode_code();
            int b, mask, clr, code, cur, fin;
            b = (cbits < 1) ? 1 : (cbits > 8) ? 8 : cbits;
            mask = (1 << b) - 1;
            while (1) begin
                clr = 1 << eff_m();
                if (held < cw) return ST_NEED;
                code = bbuf & ((1 << cw) - 1);
                bbuf = bbuf >> cw;
                held -= cw;
                if (code == clr) begin
                    restart();
                    continue;
                end
                if (code == clr + 1) begin
                    mode = MODE_ENDED;
                    return ST_END;
                end
                if (mode == MODE_AFTER_CLEAR) begin
                    if (code > clr) begin
                        go_corrupt();
                        return ST_CORRUPT;
                    end
                    fin = code & mask;
                    void'(stack_push(fin));
                    prev = code;
                    lfc = fin;
                    mode = MODE_NORMAL;
                    return ST_PIXEL;
                end
                if (code > nfc || (code == nfc && nfc >= TBL)) begin
                    go_corrupt();
                    return ST_CORRUPT;
                end
                cur = code;
                if (code == nfc) begin
                    void'(stack_push(lfc));
                    cur = prev;
                end
                while (cur >= clr) begin
                    if (cur >= TBL || !stack_push(suffix[cur])) begin
                        go_corrupt();
                        return ST_CORRUPT;
                    end
                    cur = prefix[cur];
                end
                fin = cur & mask;
                if (!stack_push(fin)) begin
                    go_corrupt();
                    return ST_CORRUPT;
                end
                if (nfc < TBL) begin
                    prefix[nfc] = prev[11:0];
                    suffix[nfc] = fin[7:0];
                    nfc++;
                    if (nfc >= (1 << cw) && cw < 12) cw++;
                end
                prev = code;
                lfc = fin;
                return ST_PIXEL;
            end
            return ST_NEED;
        endfunction

        function void note_input(logic req, logic [7:0] b);
            pixel_t r;
            r.st = ST_PIXEL; r.idx = 0; r.x = 0; r.y = 0; r.inimg = 0;
            if (req == REQ_PUSH) begin
                if (held + 8 > 24) begin
                    r.st = ST_FULL;
                end else begin
                    bbuf = bbuf | (24'(b) << held);
                    held += 8;
                    r.st = ST_TAKEN;
                end
            end else if (sc == 0 && mode == MODE_ENDED) begin
                r.st = ST_END;
            end else if (sc == 0 && mode == MODE_CORRUPT) begin
                r.st = ST_CORRUPT;
            end else begin
                r.st = (sc != 0) ? ST_PIXEL : decode_code();
                if (r.st == ST_PIXEL && sc > 0) begin
                    sc--;
                    r.idx = stk[sc];
                    r.x = col[15:0];
                    r.y = row[15:0];
                    r.inimg = (row < ih);
                    step_pos();
                end
            end
            exp_q.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check(logic [2:0] st, logic [7:0] idx, logic [15:0] x, logic [15:0] y,
                   logic inimg);
            pixel_t e;
            if (exp_q.size() == 0) begin
                report("result with nothing pending, status", st, 0);
                return;
            end
            e = exp_q.pop_front();
            if (st !== e.st) report("status", st, e.st);
            if (idx !== e.idx) report("pixel_index", idx, e.idx);
            if (x !== e.x) report("pixel_x", x, e.x);
            if (y !== e.y) report("pixel_y", y, e.y);
            if (inimg !== e.inimg) report("pixel_in_image", inimg, e.inimg);
        endtask
    endclass

    logic        aclk = 0;
    logic        aresetn;
    logic        s_valid, s_ready, s_req_type;
    logic [7:0]  s_data_byte;
    logic        m_valid, m_ready;
    logic [2:0]  m_status;
    logic [7:0]  m_pixel_index;
    logic [15:0] m_pixel_x, m_pixel_y;
    logic        m_pixel_in_image;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    pixel_scoreboard sb = new();
    int   cyc = 0;
    int   items = 0;
    bit   calm_tx = 0;

    // Code stream builder: mirrors the dictionary growth the decoder will see.
    int   g_m, g_w, g_nfc, g_mode, g_skip, g_nacc;
    longint g_acc;
    logic [7:0] byte_q[$];

    gif_lzw_pixel_decoder u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_data_byte(s_data_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_pixel_index(m_pixel_index),
        .m_pixel_x(m_pixel_x), .m_pixel_y(m_pixel_y),
        .m_pixel_in_image(m_pixel_in_image),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    always @(posedge aclk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check(m_status, m_pixel_index, m_pixel_x, m_pixel_y, m_pixel_in_image);
        end
    end

    // Receiver: one long hold-off to back up the block, one calm window.
    always @(posedge aclk) begin
        if (cyc >= 800 && cyc < 1100) begin
            m_ready <= 1'b0;
        end else if (cyc >= 1400 && cyc < 2000) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 24);
        end
    end

    function void gen_update(int code);
        int clr;
        clr = 1 << g_m;
        if (code == clr) begin
            g_w = g_m + 1;
            g_nfc = clr + 2;
            g_mode = 0;
        end else if (code == clr + 1) begin
            g_mode = 2;
        end else if (g_mode == 0) begin
            g_mode = 1;
        end else if (g_nfc < TBL) begin
            g_nfc++;
            if (g_nfc >= (1 << g_w) && g_w < 12) g_w++;
        end
    endfunction

    // Leftover zero padding in the buffer is read first as root code zero.
    function void gen_begin(int p);
        g_m = sb.eff_m();
        g_w = g_m + 1;
        g_nfc = (1 << g_m) + 2;
        g_mode = 0;
        g_acc = 0;
        g_nacc = 0;
        while (p >= g_w) begin
            gen_update(0);
            p -= g_w;
        end
        g_skip = p;
    endfunction

    function void gen_emit(int code);
        g_acc = g_acc | (longint'(code >> g_skip) << g_nacc);
        g_nacc += g_w - g_skip;
        g_skip = 0;
        while (g_nacc >= 8) begin
            byte_q.push_back(g_acc[7:0]);
            g_acc = g_acc >> 8;
            g_nacc -= 8;
        end
        gen_update(code);
    endfunction

    function void gen_end();
        gen_emit((1 << g_m) + 1);
        if (g_nacc > 0) byte_q.push_back(g_acc[7:0]);
    endfunction

    function void gen_stream(int ncodes);
        int clr, r, c;
        clr = 1 << g_m;
        if (g_skip != 0 || $urandom_range(0, 3) != 0) gen_emit(clr);
        for (int i = 0; i < ncodes; i++) begin
            r = $urandom_range(0, 99);
            if (g_mode == 0) begin
                c = $urandom_range(0, clr - 1);
            end else if (r < 3) begin
                c = clr;
            end else if (r < 18 && g_nfc < TBL) begin
                c = g_nfc;
            end else begin
                c = $urandom_range(0, g_nfc - 1);
                if (c == clr || c == clr + 1) c = (g_nfc > clr + 2) ? clr + 2 : 0;
            end
            gen_emit(c);
        end
        gen_end();
    endfunction

    task send_item(logic req, logic [7:0] b);
        if (!calm_tx && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req_type <= req;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(req, b);
        items++;
    endtask

    task wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.exp_q.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    task cfg_write(logic [2:0] idx, logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        sb.write_reg(idx, v);
        @(posedge aclk);
    endtask

    task cfg_phase(int cb, int mc, int w, int h, int il);
        cfg_write(REG_COLOR_BITS, 16'(cb));
        cfg_write(REG_IMAGE_WIDTH, 16'(w));
        cfg_write(REG_IMAGE_HEIGHT, 16'(h));
        cfg_write(REG_INTERLACED, 16'(il));
        cfg_write(REG_MIN_CODE_SIZE, 16'(mc));
        cfg_wr_en <= 1'b0;
        gen_begin(sb.held);
    endtask

    // Feeds the pending bytes and fetches pixels until the stream is used up.
    // Once decoding has stopped, bytes still pending are dropped.
    task run_phase(int push_pct);
        int tail;
        bit done;
        tail = 0;
        while (1) begin
            done = (sb.sc == 0) &&
                   (sb.mode == MODE_ENDED || sb.mode == MODE_CORRUPT ||
                    (byte_q.size() == 0 && sb.held < sb.cw));
            if (done) begin
                if (tail >= 2) break;
                tail++;
            end
            if (byte_q.size() > 0 && sb.held + 8 <= 24 &&
                    $urandom_range(0, 99) < push_pct) begin
                send_item(REQ_PUSH, byte_q.pop_front());
            end else if (sb.held + 8 > 24 && $urandom_range(0, 99) < 10) begin
                send_item(REQ_PUSH, 8'($urandom_range(0, 255)));
            end else begin
                send_item(REQ_FETCH, 8'($urandom_range(0, 255)));
            end
        end
        byte_q.delete();
        wait_drained();
    endtask

    function int pick_dim();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 1;
            2: return 65535;
            default: return $urandom_range(1, 9);
        endcase
    endfunction

    initial begin
        int ph;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = REQ_PUSH;
        s_data_byte = 8'd0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_COLOR_BITS;
        cfg_wdata = 16'd0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings, stream without a leading clear: roots at both ends,
        // KwKwK codes, a clear mid-stream, then fetches past the end code.
        gen_begin(0);
        send_item(REQ_FETCH, 8'hff);
        gen_emit(255);
        gen_emit(0);
        gen_emit(g_nfc);
        gen_emit(256);
        gen_emit(17);
        gen_emit(g_nfc);
        gen_emit(g_nfc - 1);
        gen_end();
        run_phase(90);

        cfg_phase(0, 0, 0, 0, 1);
        gen_stream(12);
        run_phase(50);
        cfg_phase(15, 15, 65535, 65535, 0);
        gen_stream(12);
        run_phase(50);

        ph = 0;
        while (items < 560) begin
            calm_tx = (ph == 3 || ph == 4);
            cfg_phase($urandom_range(0, 15), $urandom_range(0, 15), pick_dim(),
                      pick_dim(), $urandom_range(0, 1));
            gen_stream($urandom_range(5, 60));
            run_phase($urandom_range(30, 70));
            ph++;
        end
        calm_tx = 0;

        // Broken data: random bytes after a clear.
        cfg_phase($urandom_range(0, 15), $urandom_range(0, 15), pick_dim(), pick_dim(),
                  $urandom_range(0, 1));
        gen_emit(1 << g_m);
        for (int i = 0; i < 20; i++) byte_q.push_back(8'($urandom_range(0, 255)));
        run_phase(50);

        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
